// ===== rtl/hrlp_pkg.sv =====
`default_nettype none
package hrlp_pkg;

    // Line buffer sizing
    localparam int LINE_CAP    = 63;
    localparam int LINE_ADDR_W = $clog2(LINE_CAP);
    localparam int LINE_CNT_W  = $clog2(LINE_CAP + 1);

    // Command queue sizing
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration port
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int SCREEN_W     = 13;
    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [SCREEN_W-1:0] SCREEN_MAX        = 13'd4096;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    // Report classification
    localparam logic [6:0] KBD_MIN_LEN   = 7'd8;
    localparam logic [6:0] MOUSE_MIN_LEN = 7'd3;
    localparam logic [7:0] SHIFT_MASK    = 8'h22;

    // Usage codes
    localparam logic [7:0] USAGE_A     = 8'h04;
    localparam logic [7:0] USAGE_Z     = 8'h1D;
    localparam logic [7:0] USAGE_1     = 8'h1E;
    localparam logic [7:0] USAGE_9     = 8'h26;
    localparam logic [7:0] USAGE_0     = 8'h27;
    localparam logic [7:0] USAGE_ENTER = 8'h28;
    localparam logic [7:0] USAGE_BKSP  = 8'h2A;
    localparam logic [7:0] USAGE_SPACE = 8'h2C;
    localparam logic [7:0] USAGE_MINUS = 8'h2D;
    localparam logic [7:0] USAGE_EQUAL = 8'h2E;
    localparam logic [7:0] USAGE_SEMI  = 8'h33;
    localparam logic [7:0] USAGE_QUOTE = 8'h34;
    localparam logic [7:0] USAGE_COMMA = 8'h36;
    localparam logic [7:0] USAGE_DOT   = 8'h37;
    localparam logic [7:0] USAGE_SLASH = 8'h38;

    localparam logic [6:0] DIGIT_SHIFT [9] = '{
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
    };

    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_BKSP  = 2'd1,
        CMD_ENTER = 2'd2,
        CMD_MOUSE = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] char_code;
        logic [2:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
    } cmd_t;

    typedef enum logic [2:0] {
        EV_CHAR_ADD  = 3'd0,
        EV_CHAR_DEL  = 3'd1,
        EV_LINE_CHAR = 3'd2,
        EV_LINE_END  = 3'd3,
        EV_POINTER   = 3'd4
    } event_kind_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [6:0]  char_code;
        logic [5:0]  line_length;
        logic [11:0] pointer_x;
        logic [11:0] pointer_y;
        logic [2:0]  buttons_now;
        logic [2:0]  buttons_before;
        logic        last_of_run;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SEND = 2'd2,
        BK_END  = 2'd3
    } back_state_t;

    // Usage code to ASCII, zero where the usage has no character
    function automatic logic [6:0] map_usage(input logic [7:0] u, input logic sh);
        logic [6:0] c;
        logic [7:0] off;
        c = '0;
        off = '0;
        if (u inside {[USAGE_A:USAGE_Z]}) begin
            off = u - USAGE_A;
            c = (sh ? 7'h41 : 7'h61) + off[6:0];
        end else if (u inside {[USAGE_1:USAGE_9]}) begin
            off = u - USAGE_1;
            c = sh ? DIGIT_SHIFT[off[3:0]] : 7'h31 + off[6:0];
        end else begin
            case (u)
                USAGE_0:     c = sh ? 7'h29 : 7'h30;
                USAGE_SPACE: c = 7'h20;
                USAGE_MINUS: c = sh ? 7'h5F : 7'h2D;
                USAGE_EQUAL: c = sh ? 7'h2B : 7'h3D;
                USAGE_SEMI:  c = sh ? 7'h3A : 7'h3B;
                USAGE_QUOTE: c = sh ? 7'h22 : 7'h27;
                USAGE_COMMA: c = sh ? 7'h3C : 7'h2C;
                USAGE_DOT:   c = sh ? 7'h3E : 7'h2E;
                USAGE_SLASH: c = sh ? 7'h3F : 7'h2F;
                default:     c = '0;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hid_report_line_and_pointer_core.sv =====
`default_nettype none
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------------------
// s_        | in        | s_valid / s_ready  | report_len, byte_zero, byte_one, byte_two
// m_        | out       | m_valid / m_ready  | event_kind, char_code, line_length, pointer_x,
//           |           |                    | pointer_y, buttons_now, buttons_before,
//           |           |                    | last_of_run
// APB       | in/out    | psel/penable/pready| paddr, pwdata, prdata (screen width and height)
//
// Flow: a report is written into the command queue at the edge it is accepted; the back
//   end pops it once idle with a free result register, and its result is presented from
//   the result register. A character, backspace or mouse report is handled in the idle
//   state alone. Enter on a non-empty line is taken in the idle state, then each stored
//   character passes through the read state (registered read port) and the send state,
//   and the end state gives the line end; Enter on an empty line gives only the line end.
// Reset: aresetn is synchronous, active low. The line store is not cleared; only entries
//   below the line count are ever read.
// Stalls: a 2-entry command queue parts the front end from the back end; the result
//   register takes a new transaction in the cycle the previous one is taken.
module hid_report_line_and_pointer_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [6:0]                      s_report_len,
    input  wire logic [7:0]                      s_byte_zero,
    input  wire logic [7:0]                      s_byte_one,
    input  wire logic [7:0]                      s_byte_two,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [2:0]                           m_event_kind,
    output logic [6:0]                           m_char_code,
    output logic [5:0]                           m_line_length,
    output logic [11:0]                          m_pointer_x,
    output logic [11:0]                          m_pointer_y,
    output logic [2:0]                           m_buttons_now,
    output logic [2:0]                           m_buttons_before,
    output logic                                 m_last_of_run,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hrlp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [hrlp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hrlp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import hrlp_pkg::*;

    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;
    cfg_reg_t            cfg_sel;
    logic                cfg_write;

    logic    q_push, q_pop, q_full, q_empty;
    cmd_t    q_cmd, q_head;
    result_t result;

    // Configuration registers: register index is the word address, low bits ignored
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_SCREEN_WIDTH:  screen_width_reg  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[SCREEN_W-1:0];
                default:           screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_SCREEN_WIDTH:  prdata = CFG_DATA_W'(screen_width_reg);
            REG_SCREEN_HEIGHT: prdata = CFG_DATA_W'(screen_height_reg);
            default:           prdata = '0;
        endcase
    end

    // Front end: accept reports, track the held key, map usages, push commands
    hrlp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_report_len (s_report_len),
        .s_byte_zero  (s_byte_zero),
        .s_byte_one   (s_byte_one),
        .s_byte_two   (s_byte_two),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    // Hold commands until the back end is free
    hrlp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_cmd),
        .pop     (q_pop),
        .dout    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Back end: line buffer, cursor, result register
    hrlp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .disp_width  (screen_width_reg),
        .disp_height (screen_height_reg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (result)
    );

    assign m_event_kind     = result.event_kind;
    assign m_char_code      = result.char_code;
    assign m_line_length    = result.line_length;
    assign m_pointer_x      = result.pointer_x;
    assign m_pointer_y      = result.pointer_y;
    assign m_buttons_now    = result.buttons_now;
    assign m_buttons_before = result.buttons_before;
    assign m_last_of_run    = result.last_of_run;
endmodule
`default_nettype wire

// ===== rtl/hrlp_ram.sv =====
`default_nettype none
module hrlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ===== rtl/hrlp_front.sv =====
`default_nettype none
module hrlp_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [6:0]   s_report_len,
    input  wire logic [7:0]   s_byte_zero,
    input  wire logic [7:0]   s_byte_one,
    input  wire logic [7:0]   s_byte_two,
    input  wire logic         q_full,
    output logic              q_push,
    output hrlp_pkg::cmd_t    q_cmd
);
    import hrlp_pkg::*;

    logic [7:0] held_key_reg, held_key_next;
    logic [6:0] mapped;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign mapped  = map_usage(s_byte_two, |(s_byte_zero & SHIFT_MASK));

    always_comb begin
        held_key_next   = held_key_reg;
        q_push          = 1'b0;
        q_cmd           = '0;
        q_cmd.kind      = CMD_CHAR;
        q_cmd.char_code = mapped;
        q_cmd.buttons   = s_byte_zero[2:0];
        q_cmd.dx        = s_byte_one;
        q_cmd.dy        = s_byte_two;
        if (accept) begin
            if (s_report_len >= KBD_MIN_LEN) begin
                if (s_byte_two == '0 && s_byte_zero == '0) begin
                    held_key_next = '0;
                end else if (!(s_byte_two != '0 && s_byte_two == held_key_reg)) begin
                    held_key_next = s_byte_two;
                    if (s_byte_two != '0) begin
                        case (s_byte_two)
                            USAGE_ENTER: begin
                                q_push     = 1'b1;
                                q_cmd.kind = CMD_ENTER;
                            end
                            USAGE_BKSP: begin
                                q_push     = 1'b1;
                                q_cmd.kind = CMD_BKSP;
                            end
                            default: begin
                                // drop usages without a character
                                q_push     = (mapped != '0);
                                q_cmd.kind = CMD_CHAR;
                            end
                        endcase
                    end
                end
            end else if (s_report_len >= MOUSE_MIN_LEN) begin
                q_push     = 1'b1;
                q_cmd.kind = CMD_MOUSE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_key_reg <= '0;
        end else begin
            held_key_reg <= held_key_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/hrlp_queue.sv =====
`default_nettype none
module hrlp_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire hrlp_pkg::cmd_t din,
    input  wire logic         pop,
    output hrlp_pkg::cmd_t    dout,
    output logic              full,
    output logic              empty
);
    import hrlp_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/hrlp_back.sv =====
`default_nettype none
module hrlp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [hrlp_pkg::SCREEN_W-1:0] disp_width,
    input  wire logic [hrlp_pkg::SCREEN_W-1:0] disp_height,
    input  wire logic                          q_empty,
    input  wire hrlp_pkg::cmd_t                q_head,
    output logic                               q_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output hrlp_pkg::result_t                  m_result
);
    import hrlp_pkg::*;

    back_state_t           state_reg, state_next;
    logic [LINE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LINE_CNT_W-1:0] idx_reg, idx_next;
    logic [11:0]           cursor_x_reg, cursor_x_next;
    logic [11:0]           cursor_y_reg, cursor_y_next;
    logic [2:0]            prior_buttons_reg, prior_buttons_next;
    logic                  out_valid_reg;
    result_t               res_reg, res_next;
    logic                  load;
    logic                  out_free;
    logic                  ram_we, ram_re;
    logic [6:0]            ram_rd_data;
    logic [11:0]           new_x, new_y;

    // Clamp pos + signed delta into [0, size-1]; size 0 acts as 1, above 4096 as 4096
    function automatic logic [11:0] move_axis(input logic [11:0] pos,
                                              input logic [7:0] delta,
                                              input logic [SCREEN_W-1:0] size);
        logic [SCREEN_W-1:0] lim;
        logic signed [13:0]  v;
        logic [SCREEN_W-1:0] hi;
        lim = (size == '0) ? SCREEN_W'(1) : ((size > SCREEN_MAX) ? SCREEN_MAX : size);
        hi  = lim - 1'b1;
        v   = $signed({2'b00, pos}) + $signed({{6{delta[7]}}, delta});
        if (v < 0) begin
            return '0;
        end else if (v[SCREEN_W-1:0] >= lim) begin
            return hi[11:0];
        end else begin
            return v[11:0];
        end
    endfunction

    assign new_x    = move_axis(cursor_x_reg, q_head.dx, disp_width);
    assign new_y    = move_axis(cursor_y_reg, q_head.dy, disp_height);
    assign out_free = !out_valid_reg || m_ready;

    hrlp_ram #(
        .WIDTH (7),
        .DEPTH (LINE_CAP)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[LINE_ADDR_W-1:0]),
        .wr_data (q_head.char_code),
        .rd_en   (ram_re),
        .rd_addr (idx_reg[LINE_ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        idx_next           = idx_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        prior_buttons_next = prior_buttons_reg;
        q_pop              = 1'b0;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        load               = 1'b0;
        res_next           = '0;
        res_next.event_kind = EV_CHAR_ADD;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        CMD_CHAR: begin
                            // drop characters once the line is full
                            if (cnt_reg != LINE_CNT_W'(LINE_CAP)) begin
                                ram_we               = 1'b1;
                                cnt_next             = cnt_reg + 1'b1;
                                load                 = 1'b1;
                                res_next.event_kind  = EV_CHAR_ADD;
                                res_next.char_code   = q_head.char_code;
                                res_next.line_length = 6'(cnt_next);
                                res_next.last_of_run = 1'b1;
                            end
                        end
                        CMD_BKSP: begin
                            if (cnt_reg != '0) begin
                                cnt_next             = cnt_reg - 1'b1;
                                load                 = 1'b1;
                                res_next.event_kind  = EV_CHAR_DEL;
                                res_next.line_length = 6'(cnt_next);
                                res_next.last_of_run = 1'b1;
                            end
                        end
                        CMD_ENTER: begin
                            if (cnt_reg == '0) begin
                                load                 = 1'b1;
                                res_next.event_kind  = EV_LINE_END;
                                res_next.last_of_run = 1'b1;
                            end else begin
                                idx_next   = '0;
                                state_next = BK_READ;
                            end
                        end
                        CMD_MOUSE: begin
                            cursor_x_next           = new_x;
                            cursor_y_next           = new_y;
                            prior_buttons_next      = q_head.buttons;
                            load                    = 1'b1;
                            res_next.event_kind     = EV_POINTER;
                            res_next.line_length    = 6'(cnt_reg);
                            res_next.pointer_x      = new_x;
                            res_next.pointer_y      = new_y;
                            res_next.buttons_now    = q_head.buttons;
                            res_next.buttons_before = prior_buttons_reg;
                            res_next.last_of_run    = 1'b1;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ: begin
                ram_re     = 1'b1;
                state_next = BK_SEND;
            end
            BK_SEND: begin
                if (out_free) begin
                    load                 = 1'b1;
                    res_next.event_kind  = EV_LINE_CHAR;
                    res_next.char_code   = ram_rd_data;
                    res_next.line_length = 6'(cnt_reg);
                    idx_next             = idx_reg + 1'b1;
                    state_next           = (idx_next == cnt_reg) ? BK_END : BK_READ;
                end
            end
            BK_END: begin
                if (out_free) begin
                    load                 = 1'b1;
                    res_next.event_kind  = EV_LINE_END;
                    res_next.last_of_run = 1'b1;
                    cnt_next             = '0;
                    state_next           = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= BK_IDLE;
            cnt_reg           <= '0;
            idx_reg           <= '0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            prior_buttons_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            idx_reg           <= idx_next;
            cursor_x_reg      <= cursor_x_next;
            cursor_y_reg      <= cursor_y_next;
            prior_buttons_reg <= prior_buttons_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = res_reg;

    a_cnt_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LINE_CNT_W'(LINE_CAP))
        else $error("line count above capacity");

    a_walk_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_READ || state_reg == BK_SEND) |-> (idx_reg < cnt_reg))
        else $error("line walk index past line count");

    a_line_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_END && out_free) |=>
            (out_valid_reg && res_reg.event_kind == EV_LINE_END && cnt_reg == '0))
        else $error("line end not issued or line not cleared");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !load)
        else $error("result register overwritten while stalled");
endmodule
`default_nettype wire
